// File: rtl/core/fbsp_pkg.sv
// ----------------------------------------------------------------------------
// fbsp_pkg
// Shared types and constants for the FAT32 boot sector parser: header
// field offsets, check limits, verdict codes and the field bundles that
// pass between the capture logic and the verdict pipeline.
// ----------------------------------------------------------------------------
package fbsp_pkg;

  // Verdict codes, in check order
  typedef enum logic [2:0] {
    ERR_OK           = 3'd0,
    ERR_SECTOR_SIZE  = 3'd1,
    ERR_CLUSTER_SIZE = 3'd2,
    ERR_TABLES       = 3'd3,
    ERR_VERSION      = 3'd4,
    ERR_ROOT_CLUSTER = 3'd5,
    ERR_INFO_SECTOR  = 3'd6
  } err_code_t;

  // Byte offsets of the parameter fields inside the header
  localparam int OFF_BPS   = 11;
  localparam int OFF_SPC   = 13;
  localparam int OFF_RSV   = 14;
  localparam int OFF_TABS  = 16;
  localparam int OFF_ROOTS = 17;
  localparam int OFF_TOT16 = 19;
  localparam int OFF_MEDIA = 21;
  localparam int OFF_SPT16 = 22;
  localparam int OFF_TOT32 = 32;
  localparam int OFF_SPT32 = 36;
  localparam int OFF_VER   = 42;
  localparam int OFF_ROOT  = 44;
  localparam int OFF_INFO  = 48;

  // Header words 2..12 (bytes 8..51) cover every field
  localparam int FIELD_FIRST_WORD = 2;
  localparam int FIELD_WORDS      = 11;
  localparam int FIELD_BASE_BYTE  = FIELD_FIRST_WORD * 4;
  localparam int FIELD_IDX_W      = 4;

  // Positions at which the field words are read back from the header memory
  localparam int READ_FIRST_POS = 50;
  localparam int READ_LAST_POS  = READ_FIRST_POS + FIELD_WORDS - 1;
  localparam int READ_BASE_POS  = READ_FIRST_POS - FIELD_FIRST_WORD;

  // Check limits
  localparam int             SORD_MIN      = 5;
  localparam int             SORD_MAX      = 12;
  localparam int             CORD_MAX      = 7;
  localparam int             SORD_INFO_MIN = 9;
  localparam int             ROOT_SHIFT    = 5;
  localparam logic [15:0]    INFO_NONE     = 16'hffff;

  // Raw header fields as captured
  typedef struct packed {
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  tabs;
    logic [15:0] roots;
    logic [15:0] tot16;
    logic [7:0]  media;
    logic [15:0] spt16;
    logic [31:0] tot32;
    logic [31:0] spt32;
    logic [15:0] ver;
    logic [31:0] root;
    logic [15:0] info;
  } params_t;

  // Decoded fields carried with a verdict
  typedef struct packed {
    err_code_t   err;
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  tabs;
    logic [31:0] spt;
    logic [31:0] tot;
    logic [31:0] root;
    logic [15:0] info;
    logic [7:0]  media;
  } fields_t;

  // Complete result item
  typedef struct packed {
    fields_t     fld;
    logic [31:0] clusters;
  } result_t;

endpackage

// File: rtl/core/fbsp_hdr_mem.sv
// ----------------------------------------------------------------------------
// fbsp_hdr_mem
// Header byte store: word-wide synchronous memory with a byte-lane write
// port and a registered word read port.
// ----------------------------------------------------------------------------
module fbsp_hdr_mem #(
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_lane,
  input  logic [7:0]    wr_byte,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [3:0][7:0] mem [WORDS];
  logic [31:0]     rd_data_r;

  // Write one byte lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_byte;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/fbsp_verdict.sv
// ----------------------------------------------------------------------------
// fbsp_verdict
// Verdict pipeline: decode and check the header fields, then form the
// data cluster count in two add stages and hold the result item in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module fbsp_verdict
  import fbsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  params_t prm,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  // Stage A: decoded fields and orders
  logic        a_v_r, a_v_nxt;
  fields_t     a_fld_r;
  logic [15:0] a_roots_r;
  logic [3:0]  a_sord_r;
  logic [2:0]  a_cord_r;

  // Stage B: partial differences
  logic        b_v_r, b_v_nxt;
  fields_t     b_fld_r;
  logic [31:0] b_diff_r;
  logic [31:0] b_sub_r;
  logic [2:0]  b_cord_r;

  // Output stage
  logic        out_v_r, out_v_nxt;
  result_t     res_r;

  logic        out_adv, b_load_ok, a_load_ok;

  // Decode signals
  fields_t     dec;
  logic [3:0]  sord;
  logic [2:0]  cord;
  logic        bps_pow2, spc_pow2;

  // Stage B / output arithmetic
  logic [31:0] spt_x;
  logic [31:0] rterm;
  logic [31:0] clusters;

  // Stage advance conditions
  assign out_adv   = ~out_v_r | ~out_stall;
  assign b_load_ok = ~b_v_r | out_adv;
  assign a_load_ok = ~a_v_r | b_load_ok;
  assign ready     = a_load_ok;

  // Decode header fields and run the checks in order
  always_comb begin
    sord = '0;
    cord = '0;
    for (int i = 0; i < 16; i++) begin
      if (prm.bps[i]) sord = 4'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (prm.spc[i]) cord = 3'(i);
    end
    bps_pow2 = (prm.bps != '0) && ((prm.bps & (prm.bps - 16'd1)) == '0);
    spc_pow2 = (prm.spc != '0) && ((prm.spc & (prm.spc - 8'd1)) == '0);

    dec.bps   = prm.bps;
    dec.spc   = prm.spc;
    dec.rsv   = prm.rsv;
    dec.tabs  = prm.tabs;
    dec.media = prm.media;
    dec.root  = prm.root;
    dec.tot   = (prm.tot16 != '0) ? {16'd0, prm.tot16} : prm.tot32;
    dec.spt   = (prm.spt32 != '0) ? prm.spt32 : {16'd0, prm.spt16};
    dec.info  = (prm.info == INFO_NONE) ? 16'd0 : prm.info;

    if (!bps_pow2 || sord < 4'(SORD_MIN) || sord > 4'(SORD_MAX)) begin
      dec.err = ERR_SECTOR_SIZE;
    end else if (!spc_pow2 || cord > 3'(CORD_MAX)) begin
      dec.err = ERR_CLUSTER_SIZE;
    end else if (prm.tabs != 8'd1 && prm.tabs != 8'd2) begin
      dec.err = ERR_TABLES;
    end else if (prm.ver != '0) begin
      dec.err = ERR_VERSION;
    end else if (prm.root == '0) begin
      dec.err = ERR_ROOT_CLUSTER;
    end else if (dec.info != '0 && sord < 4'(SORD_INFO_MIN)) begin
      dec.err = ERR_INFO_SECTOR;
    end else begin
      dec.err = ERR_OK;
    end
  end

  // Table sectors times count (count is 1 or 2 when the checks pass) and root dir sectors
  assign spt_x = (a_fld_r.tabs == 8'd2) ? {a_fld_r.spt[30:0], 1'b0} : a_fld_r.spt;
  assign rterm = 32'({a_roots_r, 5'b0} >> a_sord_r);

  // Final difference, scaled down by the cluster order
  assign clusters = (b_fld_r.err == ERR_OK) ? ((b_diff_r - b_sub_r) >> b_cord_r) : 32'd0;

  // Advance valid flags
  always_comb begin
    a_v_nxt   = a_load_ok ? start   : a_v_r;
    b_v_nxt   = b_load_ok ? a_v_r   : b_v_r;
    out_v_nxt = out_adv   ? b_v_r   : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Load stage payloads
  always_ff @(posedge clk) begin
    if (start && a_load_ok) begin
      a_fld_r   <= dec;
      a_roots_r <= prm.roots;
      a_sord_r  <= sord;
      a_cord_r  <= cord;
    end
    if (a_v_r && b_load_ok) begin
      b_fld_r  <= a_fld_r;
      b_diff_r <= a_fld_r.tot - {16'd0, a_fld_r.rsv};
      b_sub_r  <= spt_x + rterm;
      b_cord_r <= a_cord_r;
    end
    if (b_v_r && out_adv) begin
      res_r.fld      <= b_fld_r;
      res_r.clusters <= clusters;
    end
  end

  assign out_valid = out_v_r;
  assign res       = res_r;

endmodule

// File: rtl/core/fat32_boot_sector_parser_core.sv
// ----------------------------------------------------------------------------
// fat32_boot_sector_parser_core
// FAT32 boot sector parameter block parser.
//
// Input channel (in_valid / in_stall): one sector byte per item, in disk
// order; in_first_byte marks byte zero and restarts the byte count. Without
// it the count wraps after SECTOR_BYTES bytes.
// Result channel (out_valid / out_stall): one item per sector, after its
// last byte: verdict code, data cluster count and the decoded fields.
// Throughput: one byte per cycle while in_stall is low. Header bytes go into a word memory; the
// field words are read back one per byte at positions 50..60 into a field
// register file, so the verdict is ready when the last byte arrives.
// After the last byte is accepted, the result item passes through stage A
// (decode), stage B and the output register before it is offered.
// Reset clears the byte count and the pipeline; the header memory is not
// cleared, every field byte is written before it is read.
// A stalled result holds in the output register; the two inner stages keep
// filling behind it, and in_stall rises only when all three are full.
// ----------------------------------------------------------------------------
module fat32_boot_sector_parser_core
  import fbsp_pkg::*;
#(
  parameter int SECTOR_BYTES = 512,
  parameter int HEADER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_data_clusters,
  output logic [15:0] out_bytes_per_sector,
  output logic [7:0]  out_sectors_per_cluster,
  output logic [15:0] out_reserved_sectors,
  output logic [7:0]  out_table_count,
  output logic [31:0] out_sectors_per_table,
  output logic [31:0] out_volume_sectors,
  output logic [31:0] out_root_cluster,
  output logic [15:0] out_info_sector,
  output logic [7:0]  out_media_descriptor
);

  localparam int POS_W     = $clog2(SECTOR_BYTES);
  localparam int HDR_WORDS = (HEADER_BYTES + 3) / 4;
  localparam int HDR_AW    = $clog2(HDR_WORDS);

  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       pos_cur;
  logic                   acc, is_last;
  logic                   wr_en, rd_en;
  logic [31:0]            rd_data;
  logic                   fld_v_r;
  logic [FIELD_IDX_W-1:0] fld_idx_r;
  logic [31:0]            fld_word_r [FIELD_WORDS];
  logic [FIELD_WORDS*32-1:0] hdr_bits;
  params_t                prm;
  logic                   vd_ready;
  result_t                res;

  assign in_stall = ~vd_ready;
  assign acc      = in_valid & ~in_stall;

  // Byte position, restarted by the first-byte mark
  assign pos_cur = in_first_byte ? '0 : pos_r;
  assign is_last = (pos_cur == POS_W'(SECTOR_BYTES - 1));
  assign pos_nxt = acc ? (is_last ? '0 : pos_cur + 1'b1) : pos_r;

  // Header writes and field word read-back
  assign wr_en = acc & ({1'b0, pos_cur} < (POS_W+1)'(HEADER_BYTES));
  assign rd_en = acc & (pos_cur >= POS_W'(READ_FIRST_POS))
                     & (pos_cur <= POS_W'(READ_LAST_POS));

  fbsp_hdr_mem #(
    .WORDS (HDR_WORDS),
    .AW    (HDR_AW)
  ) u_hdr_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_cur[HDR_AW+1:2]),
    .wr_lane (pos_cur[1:0]),
    .wr_byte (in_data_byte),
    .rd_en   (rd_en),
    .rd_addr (HDR_AW'(pos_cur - POS_W'(READ_BASE_POS))),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fld_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      fld_v_r <= rd_en;
    end
  end

  // Track which field word returns next cycle, then store it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fld_idx_r <= FIELD_IDX_W'(pos_cur - POS_W'(READ_FIRST_POS));
    end
    if (fld_v_r) begin
      fld_word_r[fld_idx_r] <= rd_data;
    end
  end

  // Flatten field words into header bytes 8..51
  always_comb begin
    for (int i = 0; i < FIELD_WORDS; i++) begin
      hdr_bits[i*32 +: 32] = fld_word_r[i];
    end
  end

  // Slice the raw little-endian fields
  always_comb begin
    prm.bps   = hdr_bits[(OFF_BPS   - FIELD_BASE_BYTE)*8 +: 16];
    prm.spc   = hdr_bits[(OFF_SPC   - FIELD_BASE_BYTE)*8 +: 8];
    prm.rsv   = hdr_bits[(OFF_RSV   - FIELD_BASE_BYTE)*8 +: 16];
    prm.tabs  = hdr_bits[(OFF_TABS  - FIELD_BASE_BYTE)*8 +: 8];
    prm.roots = hdr_bits[(OFF_ROOTS - FIELD_BASE_BYTE)*8 +: 16];
    prm.tot16 = hdr_bits[(OFF_TOT16 - FIELD_BASE_BYTE)*8 +: 16];
    prm.media = hdr_bits[(OFF_MEDIA - FIELD_BASE_BYTE)*8 +: 8];
    prm.spt16 = hdr_bits[(OFF_SPT16 - FIELD_BASE_BYTE)*8 +: 16];
    prm.tot32 = hdr_bits[(OFF_TOT32 - FIELD_BASE_BYTE)*8 +: 32];
    prm.spt32 = hdr_bits[(OFF_SPT32 - FIELD_BASE_BYTE)*8 +: 32];
    prm.ver   = hdr_bits[(OFF_VER   - FIELD_BASE_BYTE)*8 +: 16];
    prm.root  = hdr_bits[(OFF_ROOT  - FIELD_BASE_BYTE)*8 +: 32];
    prm.info  = hdr_bits[(OFF_INFO  - FIELD_BASE_BYTE)*8 +: 16];
  end

  // Verdict pipeline, launched by the last byte of a sector
  fbsp_verdict u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc & is_last),
    .prm       (prm),
    .ready     (vd_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Drive result ports
  assign out_error_code          = res.fld.err;
  assign out_data_clusters       = res.clusters;
  assign out_bytes_per_sector    = res.fld.bps;
  assign out_sectors_per_cluster = res.fld.spc;
  assign out_reserved_sectors    = res.fld.rsv;
  assign out_table_count         = res.fld.tabs;
  assign out_sectors_per_table   = res.fld.spt;
  assign out_volume_sectors      = res.fld.tot;
  assign out_root_cluster        = res.fld.root;
  assign out_info_sector         = res.fld.info;
  assign out_media_descriptor    = res.fld.media;

endmodule
